@@ hdl/tgsc_pkg.sv @@
// Package for the timing gate stopwatch controller.
// Holds the request and response word types, state and code enums and constants.
// It depends on nothing else.
package tgsc_pkg;

   localparam int unsigned NUM_DIGITS = 7;
   localparam int unsigned HOLDOFF_WIDTH = 16;
   localparam int unsigned CHAN_WIDTH = 7;

   localparam logic [HOLDOFF_WIDTH-1:0] HOLDOFF_RESET = 16'd1000;
   localparam logic [HOLDOFF_WIDTH-1:0] HOLDOFF_MAX = 16'hFFFF;
   localparam logic [CHAN_WIDTH-1:0] CHAN_BLUE = 7'd11;
   localparam logic [CHAN_WIDTH-1:0] CHAN_RED = 7'd91;

   localparam logic [1:0] CMD_BEGIN = 2'd1;
   localparam logic [1:0] CMD_END = 2'd2;

   // Digit order: milli ones up to minute tens.
   localparam logic [3:0] DIGIT_MAX [NUM_DIGITS] = '{
      4'd9, 4'd9, 4'd9, 4'd9, 4'd5, 4'd9, 4'd5
   };

   typedef enum logic [1:0] {
      GATE_IDLE   = 2'd0,
      GATE_RUN    = 2'd1,
      GATE_FROZEN = 2'd2,
      GATE_READY  = 2'd3
   } gate_state_type;

   typedef enum logic [1:0] {
      MODE_START  = 2'd0,
      MODE_INTER  = 2'd1,
      MODE_FINISH = 2'd2
   } gate_mode_type;

   typedef enum logic [1:0] {
      MSG_NONE  = 2'd0,
      MSG_BEGIN = 2'd1,
      MSG_END   = 2'd2,
      MSG_IDLE  = 2'd3
   } message_type;

   typedef struct packed {
      logic       team_button;
      logic       mode_button;
      logic       beam_broken;
      logic [1:0] radio_command;
   } req_word_type;

   typedef struct packed {
      logic [1:0]            gate_state;
      logic [1:0]            gate_mode;
      logic [CHAN_WIDTH-1:0] radio_channel;
      logic [1:0]            outgoing_message;
      logic [2:0]            minute_tens;
      logic [3:0]            minute_ones;
      logic [2:0]            second_tens;
      logic [3:0]            second_ones;
      logic [3:0]            milli_hundreds;
      logic [3:0]            milli_tens;
      logic [3:0]            milli_ones;
      logic                  team_blue;
   } rsp_word_type;

endpackage

@@ hdl/timing_gate_stopwatch_controller_core.sv @@
// Top level of the timing gate stopwatch controller.
// Gate state machine, BCD stopwatch, hold-off counter and a two-entry result buffer.
// It depends on tgsc_pkg.

// Each request word is one 1 ms tick and yields exactly one response word showing the gate
// after that tick. A word is taken every clock cycle while req_stall is low: the state
// update is one pass of logic between the state registers and the result register, and a
// skid entry behind the result register keeps input accepted while the response stalls.
// req_stall is a registered signal and rises only once the skid entry is occupied. The
// hold-off length register is written through the csr port, which is always ready.
module timing_gate_stopwatch_controller_core (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  tgsc_pkg::req_word_type                   req_data,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output tgsc_pkg::rsp_word_type                   rsp_data,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [tgsc_pkg::HOLDOFF_WIDTH-1:0]       csr_data
);
   import tgsc_pkg::*;

   logic [HOLDOFF_WIDTH-1:0] holdoff_ticks_ff;
   gate_state_type           state_ff, state_in;
   gate_mode_type            mode_ff, mode_in;
   logic                     team_ff, team_in;
   message_type              msg_ff, msg_in;
   logic [HOLDOFF_WIDTH-1:0] count_ff, count_in;
   logic [3:0]               digits_ff [NUM_DIGITS];
   logic [3:0]               digits_in [NUM_DIGITS];
   logic [3:0]               advanced [NUM_DIGITS];
   logic [HOLDOFF_WIDTH-1:0] count_inc;

   logic                     accept;
   logic                     out_take;
   rsp_word_type             result;
   rsp_word_type             out_ff, out_in;
   rsp_word_type             skid_ff, skid_in;
   logic                     out_valid_ff, out_valid_in;
   logic                     skid_valid_ff, skid_valid_in;

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign accept = req_valid && !req_stall;
   assign out_take = out_valid_ff && !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_ff;

   always_comb begin
      logic carry;
      carry = 1'b1;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         advanced[i] = digits_ff[i];
         if (carry) begin
            if (digits_ff[i] < DIGIT_MAX[i]) begin
               advanced[i] = digits_ff[i] + 4'd1;
               carry = 1'b0;
            end else begin
               advanced[i] = 4'd0;
            end
         end
      end
   end

   assign count_inc = (count_ff < HOLDOFF_MAX) ? count_ff + 16'd1 : count_ff;

   always_comb begin
      state_in = state_ff;
      mode_in = mode_ff;
      team_in = team_ff;
      msg_in = msg_ff;
      count_in = count_ff;
      digits_in = digits_ff;
      if (accept) begin
         unique case (state_ff)
            GATE_IDLE: begin
               if (req_data.team_button) begin
                  team_in = !team_ff;
               end
               if (req_data.mode_button) begin
                  unique case (mode_ff)
                     MODE_START: mode_in = MODE_INTER;
                     MODE_INTER: mode_in = MODE_FINISH;
                     default:    mode_in = MODE_START;
                  endcase
               end else if (req_data.beam_broken && mode_ff == MODE_START) begin
                  state_in = GATE_RUN;
                  msg_in = MSG_BEGIN;
               end else if (req_data.radio_command == CMD_BEGIN && mode_ff != MODE_START) begin
                  state_in = GATE_RUN;
                  msg_in = MSG_BEGIN;
               end
            end
            GATE_RUN: begin
               digits_in = advanced;
               if (req_data.team_button) begin
                  digits_in = '{default: 4'd0};
                  state_in = GATE_IDLE;
               end
               if (req_data.radio_command == CMD_END) begin
                  state_in = GATE_FROZEN;
                  msg_in = MSG_END;
                  count_in = '0;
               end
               if (req_data.beam_broken && mode_ff == MODE_INTER) begin
                  state_in = GATE_FROZEN;
                  msg_in = MSG_IDLE;
                  count_in = '0;
               end
               if (req_data.beam_broken && mode_ff == MODE_FINISH) begin
                  state_in = GATE_FROZEN;
                  msg_in = MSG_END;
                  count_in = '0;
               end
            end
            GATE_FROZEN: begin
               count_in = count_inc;
               if (count_inc >= holdoff_ticks_ff) begin
                  msg_in = MSG_IDLE;
                  state_in = GATE_READY;
               end
            end
            GATE_READY: begin
               if (req_data.team_button) begin
                  digits_in = '{default: 4'd0};
                  state_in = GATE_IDLE;
               end
               if (req_data.radio_command == CMD_BEGIN) begin
                  digits_in = '{default: 4'd0};
                  state_in = GATE_RUN;
               end
            end
            default: begin
               state_in = GATE_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      result.gate_state = state_in;
      result.gate_mode = mode_in;
      result.radio_channel = team_in ? CHAN_BLUE : CHAN_RED;
      result.outgoing_message = msg_in;
      result.minute_tens = digits_in[6][2:0];
      result.minute_ones = digits_in[5];
      result.second_tens = digits_in[4][2:0];
      result.second_ones = digits_in[3];
      result.milli_hundreds = digits_in[2];
      result.milli_tens = digits_in[1];
      result.milli_ones = digits_in[0];
      result.team_blue = team_in;
   end

   always_comb begin
      out_in = out_ff;
      out_valid_in = out_valid_ff;
      skid_in = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_take || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_in = skid_ff;
            out_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in = result;
            out_valid_in = accept;
         end
      end else if (accept) begin
         skid_in = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         holdoff_ticks_ff <= HOLDOFF_RESET;
         state_ff <= GATE_IDLE;
         mode_ff <= MODE_START;
         team_ff <= 1'b0;
         msg_ff <= MSG_NONE;
         count_ff <= '0;
         digits_ff <= '{default: 4'd0};
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            holdoff_ticks_ff <= csr_data;
         end
         state_ff <= state_in;
         mode_ff <= mode_in;
         team_ff <= team_in;
         msg_ff <= msg_in;
         count_ff <= count_in;
         digits_ff <= digits_in;
         out_valid_ff <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      skid_ff <= skid_in;
   end

`ifndef SYNTHESIS
   // The skid entry is only ever filled behind a held response.
   assert property (@(posedge clock) disable iff (reset) skid_valid_ff |-> out_valid_ff)
      else $error("skid entry occupied while the response register is empty");

   // The ready state is reached only through the end of the hold-off.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == GATE_READY |-> msg_ff == MSG_IDLE)
      else $error("ready state without the idle message");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == GATE_FROZEN |-> (msg_ff == MSG_END || msg_ff == MSG_IDLE))
      else $error("frozen state with a begin or empty message");

   // An accepted word always produces a pending response on the next cycle.
   assert property (@(posedge clock) disable iff (reset) accept |=> out_valid_ff)
      else $error("accepted word produced no response");
`endif

endmodule

@@ dv/tgsc_gate_checker.sv @@
// Checker for the timing gate stopwatch controller: watches the request, response and csr
// channels, predicts every response word and compares it field by field.
// It depends on tgsc_pkg.
module tgsc_gate_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  tgsc_pkg::req_word_type              req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  tgsc_pkg::rsp_word_type              rsp_data,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [tgsc_pkg::HOLDOFF_WIDTH-1:0]  csr_data,
   output int unsigned                         fail_count,
   output int unsigned                         words_due
);
   timeunit 1ns;
   timeprecision 1ps;
   import tgsc_pkg::*;

   localparam logic [3:0] WATCH_TOP [7] = '{
      4'd9, 4'd9, 4'd9, 4'd9, 4'd5, 4'd9, 4'd5
   };

   gate_state_type gate_now;
   gate_mode_type  mode_now;
   message_type    msg_now;
   logic           blue_now;
   logic [3:0]     watch [7];
   logic [15:0]    frozen_ticks;
   logic [15:0]    holdoff_len;
   rsp_word_type   readouts_due [$];
   int unsigned    bad_fields = 0;
   int unsigned    stray_words = 0;

   function automatic void clear_watch();
      for (int i = 0; i < 7; i++) watch[i] = 4'd0;
   endfunction

   function automatic void freeze_gate(input message_type m);
      gate_now = GATE_FROZEN;
      msg_now = m;
      frozen_ticks = 16'd0;
   endfunction

   // Applies one tick to the predicted gate and returns the word it should show.
   function automatic rsp_word_type step_gate(input req_word_type w);
      rsp_word_type r;
      logic carry;
      case (gate_now)
         GATE_IDLE: begin
            if (w.team_button) blue_now = !blue_now;
            if (w.mode_button) begin
               case (mode_now)
                  MODE_START: mode_now = MODE_INTER;
                  MODE_INTER: mode_now = MODE_FINISH;
                  default: mode_now = MODE_START;
               endcase
            end else if ((w.beam_broken && mode_now == MODE_START) ||
                         (w.radio_command == CMD_BEGIN && mode_now != MODE_START)) begin
               gate_now = GATE_RUN;
               msg_now = MSG_BEGIN;
            end
         end
         GATE_RUN: begin
            carry = 1'b1;
            for (int i = 0; i < 7; i++) begin
               if (carry) begin
                  if (watch[i] < WATCH_TOP[i]) begin
                     watch[i] = watch[i] + 4'd1;
                     carry = 1'b0;
                  end else begin
                     watch[i] = 4'd0;
                  end
               end
            end
            if (w.team_button) begin
               clear_watch();
               gate_now = GATE_IDLE;
            end
            if (w.radio_command == CMD_END) freeze_gate(MSG_END);
            if (w.beam_broken && mode_now == MODE_INTER) freeze_gate(MSG_IDLE);
            if (w.beam_broken && mode_now == MODE_FINISH) freeze_gate(MSG_END);
         end
         GATE_FROZEN: begin
            if (frozen_ticks != 16'hFFFF) frozen_ticks = frozen_ticks + 16'd1;
            if (frozen_ticks >= holdoff_len) begin
               msg_now = MSG_IDLE;
               gate_now = GATE_READY;
            end
         end
         default: begin
            if (w.team_button) begin
               clear_watch();
               gate_now = GATE_IDLE;
            end
            if (w.radio_command == CMD_BEGIN) begin
               clear_watch();
               gate_now = GATE_RUN;
            end
         end
      endcase
      r.gate_state = gate_now;
      r.gate_mode = mode_now;
      r.radio_channel = blue_now ? CHAN_BLUE : CHAN_RED;
      r.outgoing_message = msg_now;
      r.minute_tens = watch[6][2:0];
      r.minute_ones = watch[5];
      r.second_tens = watch[4][2:0];
      r.second_ones = watch[3];
      r.milli_hundreds = watch[2];
      r.milli_tens = watch[1];
      r.milli_ones = watch[0];
      r.team_blue = blue_now;
      return r;
   endfunction

   task automatic compare_field(input string label, input logic [7:0] want,
                                input logic [7:0] got);
      if (want !== got) begin
         $display("%0t ns: %s expected %0d, actual %0d", $time, label, want, got);
         bad_fields++;
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         gate_now = GATE_IDLE;
         mode_now = MODE_START;
         msg_now = MSG_NONE;
         blue_now = 1'b0;
         clear_watch();
         frozen_ticks = 16'd0;
         holdoff_len = HOLDOFF_RESET;
         readouts_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (readouts_due.size() == 0) begin
               $display("%0t ns: response word expected none, actual %h", $time, rsp_data);
               stray_words++;
            end else begin
               want = readouts_due.pop_front();
               compare_field("gate_state", want.gate_state, rsp_data.gate_state);
               compare_field("gate_mode", want.gate_mode, rsp_data.gate_mode);
               compare_field("radio_channel", want.radio_channel, rsp_data.radio_channel);
               compare_field("outgoing_message", want.outgoing_message,
                             rsp_data.outgoing_message);
               compare_field("minute_tens", want.minute_tens, rsp_data.minute_tens);
               compare_field("minute_ones", want.minute_ones, rsp_data.minute_ones);
               compare_field("second_tens", want.second_tens, rsp_data.second_tens);
               compare_field("second_ones", want.second_ones, rsp_data.second_ones);
               compare_field("milli_hundreds", want.milli_hundreds, rsp_data.milli_hundreds);
               compare_field("milli_tens", want.milli_tens, rsp_data.milli_tens);
               compare_field("milli_ones", want.milli_ones, rsp_data.milli_ones);
               compare_field("team_blue", want.team_blue, rsp_data.team_blue);
            end
         end
         if (csr_valid && csr_ready) holdoff_len = csr_data;
         if (req_valid && !req_stall) readouts_due.push_back(step_gate(req_data));
      end
      fail_count = bad_fields + stray_words;
      words_due = readouts_due.size();
   end

endmodule

@@ dv/testbench.sv @@
// Top of the timing gate stopwatch controller testbench: clock, reset, tick stimulus,
// hold-off writes, random idling on both channels and the verdict.
// It depends on tgsc_pkg, tgsc_gate_checker and timing_gate_stopwatch_controller_core.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import tgsc_pkg::*;

   localparam int unsigned QUIET_LIMIT = 5000;
   localparam logic [1:0] CMD_NONE = 2'd0;
   localparam logic [1:0] CMD_SPARE = 2'd3;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [15:0]  csr_data = '0;
   int unsigned  fail_count;
   int unsigned  words_due;
   int unsigned  quiet_cycles = 0;
   logic         gaps_on = 1'b1;

   always #10 clock = ~clock;

   timing_gate_stopwatch_controller_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   tgsc_gate_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .words_due  (words_due)
   );

   always @(posedge clock) begin
      rsp_stall <= gaps_on && ($urandom_range(99) < 7);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_word_type word_of(input logic team, input logic mode,
                                            input logic beam, input logic [1:0] cmd);
      req_word_type w;
      w.team_button = team;
      w.mode_button = mode;
      w.beam_broken = beam;
      w.radio_command = cmd;
      return w;
   endfunction

   function automatic req_word_type busy_word();
      req_word_type w;
      int unsigned c;
      c = $urandom_range(99);
      w.team_button = ($urandom_range(99) < 4);
      w.mode_button = ($urandom_range(99) < 8);
      w.beam_broken = ($urandom_range(99) < 12);
      if (c < 8) w.radio_command = CMD_BEGIN;
      else if (c < 14) w.radio_command = CMD_END;
      else if (c < 18) w.radio_command = CMD_SPARE;
      else w.radio_command = CMD_NONE;
      return w;
   endfunction

   // Content that leaves a running gate running, whatever its mode.
   function automatic req_word_type run_word();
      int unsigned c;
      c = $urandom_range(2);
      return word_of(1'b0, 1'($urandom_range(1)), 1'b0,
                     (c == 0) ? CMD_NONE : ((c == 1) ? CMD_BEGIN : CMD_SPARE));
   endfunction

   task automatic send_tick(input req_word_type w);
      while (gaps_on && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
   endtask

   task automatic await_drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (words_due != 0);
      @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_holdoff(input logic [15:0] ticks);
      await_drain();
      csr_valid <= 1'b1;
      csr_data <= ticks;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase(input int unsigned n);
      int unsigned sent;
      int unsigned pick;
      int unsigned len;
      sent = 0;
      while (sent < n) begin
         pick = $urandom_range(99);
         if (pick < 20) begin
            len = $urandom_range(80, 20);
            send_tick(word_of(1'b0, 1'b0, 1'b1, CMD_BEGIN));
            repeat (len) send_tick(run_word());
            send_tick(word_of(1'b0, 1'b0, 1'b0, CMD_END));
            sent += len + 2;
         end else if (pick < 90) begin
            len = $urandom_range(60, 20);
            repeat (len) send_tick(busy_word());
            sent += len;
         end else if (pick < 97) begin
            len = $urandom_range(20, 5);
            repeat (len) send_tick(req_word_type'(5'($urandom)));
            sent += len;
         end else begin
            await_drain();
         end
      end
   endtask

   initial begin
      logic [15:0] setting;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // With a zero hold-off the gate is ready on the first frozen tick.
      write_holdoff(16'd0);
      send_tick(word_of(1'b1, 1'b0, 1'b0, CMD_NONE));
      send_tick(word_of(1'b1, 1'b0, 1'b0, CMD_NONE));
      send_tick(word_of(1'b0, 1'b0, 1'b1, CMD_SPARE));
      send_tick(word_of(1'b0, 1'b0, 1'b0, CMD_SPARE));
      send_tick(word_of(1'b0, 1'b1, 1'b1, CMD_BEGIN));
      send_tick(word_of(1'b0, 1'b0, 1'b0, CMD_END));
      send_tick(word_of(1'b1, 1'b1, 1'b1, CMD_SPARE));
      send_tick(word_of(1'b0, 1'b0, 1'b0, CMD_BEGIN));
      send_tick(word_of(1'b0, 1'b0, 1'b0, CMD_NONE));
      send_tick(word_of(1'b1, 1'b0, 1'b0, CMD_END));
      send_tick(word_of(1'b0, 1'b0, 1'b0, CMD_NONE));
      send_tick(word_of(1'b1, 1'b0, 1'b0, CMD_NONE));
      send_tick(word_of(1'b0, 1'b1, 1'b0, CMD_NONE));
      send_tick(word_of(1'b0, 1'b0, 1'b1, CMD_NONE));
      send_tick(word_of(1'b0, 1'b0, 1'b0, CMD_BEGIN));
      send_tick(word_of(1'b0, 1'b0, 1'b1, CMD_NONE));
      send_tick(word_of(1'b0, 1'b0, 1'b0, CMD_NONE));
      send_tick(word_of(1'b1, 1'b0, 1'b0, CMD_BEGIN));
      send_tick(word_of(1'b1, 1'b0, 1'b1, CMD_NONE));
      send_tick(word_of(1'b0, 1'b0, 1'b0, CMD_NONE));
      send_tick(word_of(1'b1, 1'b0, 1'b0, CMD_NONE));
      send_tick(word_of(1'b1, 1'b1, 1'b1, CMD_BEGIN));
      send_tick(word_of(1'b0, 1'b0, 1'b0, CMD_BEGIN));
      send_tick(word_of(1'b0, 1'b0, 1'b1, CMD_END));
      send_tick(word_of(1'b0, 1'b0, 1'b0, CMD_NONE));
      send_tick(word_of(1'b1, 1'b1, 1'b0, CMD_NONE));
      send_tick(word_of(1'b0, 1'b1, 1'b0, CMD_NONE));

      // A run of just over a second carries the stopwatch into the seconds digits.
      write_holdoff(16'd30);
      send_tick(word_of(1'b0, 1'b0, 1'b1, CMD_BEGIN));
      repeat (1005) send_tick(run_word());
      send_tick(word_of(1'b0, 1'b0, 1'b0, CMD_END));
      repeat (32) send_tick(req_word_type'(5'($urandom)));
      send_tick(word_of(1'b1, 1'b0, 1'b0, CMD_NONE));

      for (int p = 0; p < 5; p++) begin
         case (p)
            0: setting = 16'd1;
            1: setting = 16'($urandom_range(12, 2));
            2: setting = 16'd0;
            3: setting = 16'($urandom_range(60, 13));
            default: setting = 16'd5;
         endcase
         write_holdoff(setting);
         gaps_on = (p != 2);
         random_phase(100);
         // Let any hold-off run out, then bring the gate back to idle.
         repeat (int'(setting) + 2) send_tick(word_of(1'b0, 1'b0, 1'b0, CMD_NONE));
         send_tick(word_of(1'b1, 1'b0, 1'b0, CMD_NONE));
      end

      await_drain();
      repeat (16) @(posedge clock);
      if (fail_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("FAIL");
      $finish;
   end

endmodule
